// ===== sv/fbde_pkg.sv =====
// Package for the framebuffer draw engine: frame geometry, command codes,
// transfer structs and the sequencer state type. Depends on nothing.
package fbde_pkg;

    localparam int FRAME_WIDTH  = 800;
    localparam int FRAME_HEIGHT = 600;
    localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(FRAME_DEPTH);
    localparam int PIX_W        = 24;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_PIXEL  = 3'd1,
        ACT_LINE   = 3'd2,
        ACT_RECT   = 3'd3,
        ACT_CIRCLE = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef struct packed {
        logic [2:0]        action;
        logic signed [11:0] x_start;
        logic signed [11:0] y_start;
        logic signed [11:0] x_end;
        logic signed [11:0] y_end;
        logic [10:0]       rect_width;
        logic [10:0]       rect_height;
        logic [10:0]       radius;
        logic [23:0]       color_rgb;
    } cmd_t;

    typedef struct packed {
        logic [23:0] read_rgb;
        logic        read_valid;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LINE,
        ST_RECT_H,
        ST_RECT_V,
        ST_CIRC_PLOT,
        ST_CIRC_STEP,
        ST_READ_WAIT,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    // One point handed from the sequencer to the pixel writer.
    typedef struct packed {
        logic               plot;
        logic signed [13:0] x;
        logic signed [13:0] y;
    } point_t;

endpackage

// ===== sv/fbde_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module fbde_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== sv/fbde_plot.sv =====
// Pixel writer: clips one point against the frame and forms its row-major
// address, registered. Depends on fbde_pkg.
module fbde_plot
    import fbde_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  point_t            pt,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr
);

    logic              inside_frame;
    logic [ADDR_W-1:0] addr_next;
    logic              wr_en_reg;
    logic [ADDR_W-1:0] wr_addr_reg;

    assign inside_frame = pt.plot && (pt.x >= 0) && (pt.y >= 0)
        && (pt.x < 14'(FRAME_WIDTH)) && (pt.y < 14'(FRAME_HEIGHT));
    assign addr_next = ADDR_W'(pt.y[10:0] * 11'(FRAME_WIDTH))
        + ADDR_W'(pt.x[10:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= 1'b0;
        end
        else
        begin
            wr_en_reg <= inside_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= addr_next;
    end

    assign wr_en   = wr_en_reg;
    assign wr_addr = wr_addr_reg;

endmodule

// ===== sv/framebuffer_2d_draw_engine.sv =====
// Top level of the framebuffer draw engine: command sequencer, pixel writer
// and frame memory. Depends on fbde_pkg, fbde_plot and fbde_ram.
//
// One command is taken at a time. A pixel is handed to the pixel writer in
// the acceptance cycle. A line takes one cycle per point, max(|dx|,|dy|)+1
// points with clipped points included. A rectangle takes one cycle per point,
// 2*(w+h) points, and draws none when w or h is zero. A circle writes eight
// points and then one update per octant step, and closes once x falls below
// y. A read waits for the registered memory output. A clear takes one cycle
// per frame entry, 480000 at 800x600. The single write port of the frame
// memory sets these rates. The result of a command is held in an output
// register. The next command may be taken while that result waits, but its
// own result holds the sequencer until the register has been moved.
module framebuffer_2d_draw_engine
    import fbde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic signed [13:0] xa_reg, xa_next, ya_reg, ya_next;
    logic signed [13:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [14:0] err_reg, err_next;
    logic signed [13:0] px_reg, px_next, py_reg, py_next;
    logic [2:0]  oct_reg, oct_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        side_reg, side_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_data_reg, out_data_next;
    point_t      pt;
    logic        pw_en, clr_en;
    logic [ADDR_W-1:0] pw_addr, wr_addr, rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic signed [13:0] cx, cy, e_x, e_y, sx, sy;
    logic signed [14:0] e2;
    logic signed [13:0] rw, rh, rdx, rdy;
    logic        rd_inside;

    assign cx  = 14'(cmd_reg.x_start);
    assign cy  = 14'(cmd_reg.y_start);
    assign e_x = 14'(cmd_reg.x_end);
    assign e_y = 14'(cmd_reg.y_end);
    assign sx  = (cx < e_x) ? 14'sd1 : -14'sd1;
    assign sy  = (cy < e_y) ? 14'sd1 : -14'sd1;
    assign e2  = err_reg <<< 1;
    assign rw  = 14'(cmd_reg.rect_width);
    assign rh  = 14'(cmd_reg.rect_height);
    assign rdx = $signed({3'b000, cnt_reg});
    assign rdy = rdx;
    assign rd_inside = (cx >= 0) && (cy >= 0) && (cx < 14'(FRAME_WIDTH))
        && (cy < 14'(FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        xa_reg       <= xa_next;
        ya_reg       <= ya_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        err_reg      <= err_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        oct_reg      <= oct_next;
        cnt_reg      <= cnt_next;
        side_reg     <= side_next;
        clr_reg      <= clr_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        logic signed [14:0] e_t;
        logic signed [13:0] px_t, py_t;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        err_next       = err_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        oct_next       = oct_reg;
        cnt_next       = cnt_reg;
        side_next      = side_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        pt             = '0;
        clr_en         = 1'b0;
        rd_addr        = ADDR_W'(cy[10:0] * 11'(FRAME_WIDTH)) + ADDR_W'(cx[10:0]);
        e_t            = err_reg;
        px_t           = px_reg;
        py_t           = py_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_data;
                    xa_next  = 14'(in_data.x_start);
                    ya_next  = 14'(in_data.y_start);
                    dx_next  = (in_data.x_end > in_data.x_start)
                        ? 14'(in_data.x_end) - 14'(in_data.x_start)
                        : 14'(in_data.x_start) - 14'(in_data.x_end);
                    dy_next  = (in_data.y_end > in_data.y_start)
                        ? 14'(in_data.y_end) - 14'(in_data.y_start)
                        : 14'(in_data.y_start) - 14'(in_data.y_end);
                    err_next = 15'(dx_next) - 15'(dy_next);
                    px_next  = 14'(in_data.radius);
                    py_next  = '0;
                    oct_next = '0;
                    cnt_next = '0;
                    side_next = 1'b0;
                    clr_next = '0;
                    unique case (in_data.action)
                        ACT_CLEAR:  state_next = ST_CLEAR;
                        ACT_PIXEL:  state_next = ST_DONE;
                        ACT_LINE:   state_next = ST_LINE;
                        ACT_RECT:
                        begin
                            if (in_data.rect_width == '0 || in_data.rect_height == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RECT_H;
                            end
                        end
                        ACT_CIRCLE:
                        begin
                            err_next   = '0;
                            state_next = ST_CIRC_PLOT;
                        end
                        ACT_READ:   state_next = ST_READ_WAIT;
                        default:    state_next = ST_DONE;
                    endcase
                    if (in_data.action == ACT_PIXEL)
                    begin
                        pt.plot = 1'b1;
                        pt.x    = 14'(in_data.x_start);
                        pt.y    = 14'(in_data.y_start);
                    end
                end
            end
            ST_CLEAR:
            begin
                clr_en   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(FRAME_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LINE:
            begin
                pt.plot = 1'b1;
                pt.x    = xa_reg;
                pt.y    = ya_reg;
                if (xa_reg == e_x && ya_reg == e_y)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (e2 > -15'(dy_reg))
                    begin
                        e_t     = e_t - 15'(dy_reg);
                        xa_next = xa_reg + sx;
                    end
                    if (e2 < 15'(dx_reg))
                    begin
                        e_t     = e_t + 15'(dx_reg);
                        ya_next = ya_reg + sy;
                    end
                    err_next = e_t;
                end
            end
            ST_RECT_H:
            begin
                pt.plot   = 1'b1;
                pt.x      = cx + rdx;
                pt.y      = side_reg ? cy + rh - 14'sd1 : cy;
                side_next = ~side_reg;
                if (side_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (rdx == rw - 14'sd1)
                    begin
                        cnt_next   = '0;
                        state_next = ST_RECT_V;
                    end
                end
            end
            ST_RECT_V:
            begin
                pt.plot   = 1'b1;
                pt.x      = side_reg ? cx + rw - 14'sd1 : cx;
                pt.y      = cy + rdy;
                side_next = ~side_reg;
                if (side_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (rdy == rh - 14'sd1)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CIRC_PLOT:
            begin
                if (px_reg < py_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pt.plot = 1'b1;
                    unique case (oct_reg)
                        3'd0: begin pt.x = cx + px_reg; pt.y = cy + py_reg; end
                        3'd1: begin pt.x = cx + py_reg; pt.y = cy + px_reg; end
                        3'd2: begin pt.x = cx - py_reg; pt.y = cy + px_reg; end
                        3'd3: begin pt.x = cx - px_reg; pt.y = cy + py_reg; end
                        3'd4: begin pt.x = cx - px_reg; pt.y = cy - py_reg; end
                        3'd5: begin pt.x = cx - py_reg; pt.y = cy - px_reg; end
                        3'd6: begin pt.x = cx + py_reg; pt.y = cy - px_reg; end
                        default: begin pt.x = cx + px_reg; pt.y = cy - py_reg; end
                    endcase
                    oct_next = oct_reg + 1'b1;
                    if (oct_reg == 3'd7)
                    begin
                        state_next = ST_CIRC_STEP;
                    end
                end
            end
            ST_CIRC_STEP:
            begin
                if (e_t <= 0)
                begin
                    py_t = py_t + 14'sd1;
                    e_t  = e_t + 15'(py_t <<< 1) + 15'sd1;
                end
                if (e_t > 0)
                begin
                    px_t = px_t - 14'sd1;
                    e_t  = e_t - 15'(px_t <<< 1) - 15'sd1;
                end
                px_next    = px_t;
                py_next    = py_t;
                err_next   = e_t;
                state_next = ST_CIRC_PLOT;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_READ_DATA;
            end
            ST_READ_DATA:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.read_rgb   = rd_inside ? rd_data : '0;
                    out_data_next.read_valid = rd_inside;
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!pw_en && (!out_valid_reg || out_ready))
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    fbde_plot u_plot (
        .clk     (clk),
        .rst_n   (rst_n),
        .pt      (pt),
        .wr_en   (pw_en),
        .wr_addr (pw_addr)
    );

    assign wr_addr = clr_en ? clr_reg : pw_addr;

    fbde_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame (
        .clk     (clk),
        .wr_en   (pw_en || clr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd_reg.color_rgb),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_en && pw_en))
        else $error("clear sweep and pixel writer collide");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !clr_en)
        else $error("clear write while idle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed before transfer");

endmodule

// ===== bench/framebuffer_2d_draw_engine_tb.sv =====
// Self-checking testbench for the framebuffer draw engine: random and directed
// commands with a frame-store predictor. Depends on fbde_pkg and the RTL top.
module framebuffer_2d_draw_engine_tb;
    import fbde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W = $bits(cmd_t);

    class frame_scoreboard;
        bit [23:0] frame[FRAME_DEPTH];
        rsp_t      pending[$];
        int        errors;

        function void put_pixel(int x, int y, bit [23:0] c);
            if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT)
                frame[y * FRAME_WIDTH + x] = c;
        endfunction

        function void note(cmd_t c);
            int xs, ys, xe, ye, w, h, r, dx, dy, sx, sy, e, e2, px, py;
            rsp_t res;
            xs = c.x_start;
            ys = c.y_start;
            xe = c.x_end;
            ye = c.y_end;
            w = c.rect_width;
            h = c.rect_height;
            r = c.radius;
            res = '0;
            case (c.action)
                ACT_CLEAR: for (int i = 0; i < FRAME_DEPTH; i++) frame[i] = c.color_rgb;
                ACT_PIXEL: put_pixel(xs, ys, c.color_rgb);
                ACT_LINE:
                begin
                    dx = (xe > xs) ? xe - xs : xs - xe;
                    dy = (ye > ys) ? ye - ys : ys - ye;
                    sx = (xs < xe) ? 1 : -1;
                    sy = (ys < ye) ? 1 : -1;
                    e = dx - dy;
                    forever
                    begin
                        put_pixel(xs, ys, c.color_rgb);
                        if (xs == xe && ys == ye) break;
                        e2 = 2 * e;
                        if (e2 > -dy)
                        begin
                            e -= dy;
                            xs += sx;
                        end
                        if (e2 < dx)
                        begin
                            e += dx;
                            ys += sy;
                        end
                    end
                end
                ACT_RECT:
                begin
                    if (w != 0 && h != 0)
                    begin
                        for (int i = xs; i < xs + w; i++)
                        begin
                            put_pixel(i, ys, c.color_rgb);
                            put_pixel(i, ys + h - 1, c.color_rgb);
                        end
                        for (int i = ys; i < ys + h; i++)
                        begin
                            put_pixel(xs, i, c.color_rgb);
                            put_pixel(xs + w - 1, i, c.color_rgb);
                        end
                    end
                end
                ACT_CIRCLE:
                begin
                    px = r;
                    py = 0;
                    e = 0;
                    while (px >= py)
                    begin
                        put_pixel(xs + px, ys + py, c.color_rgb);
                        put_pixel(xs + py, ys + px, c.color_rgb);
                        put_pixel(xs - py, ys + px, c.color_rgb);
                        put_pixel(xs - px, ys + py, c.color_rgb);
                        put_pixel(xs - px, ys - py, c.color_rgb);
                        put_pixel(xs - py, ys - px, c.color_rgb);
                        put_pixel(xs + py, ys - px, c.color_rgb);
                        put_pixel(xs + px, ys - py, c.color_rgb);
                        if (e <= 0)
                        begin
                            py += 1;
                            e += 2 * py + 1;
                        end
                        if (e > 0)
                        begin
                            px -= 1;
                            e -= 2 * px + 1;
                        end
                    end
                end
                ACT_READ:
                begin
                    if (xs >= 0 && xs < FRAME_WIDTH && ys >= 0 && ys < FRAME_HEIGHT)
                    begin
                        res.read_rgb = frame[ys * FRAME_WIDTH + xs];
                        res.read_valid = 1'b1;
                    end
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check(rsp_t got);
            rsp_t exp_rsp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%b",
                         $realtime, got.read_rgb, got.read_valid);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            if (got.read_rgb !== exp_rsp.read_rgb)
            begin
                $display("%0t: read_rgb mismatch, expected %h, actual %h",
                         $realtime, exp_rsp.read_rgb, got.read_rgb);
                errors++;
            end
            if (got.read_valid !== exp_rsp.read_valid)
            begin
                $display("%0t: read_valid mismatch, expected %b, actual %b",
                         $realtime, exp_rsp.read_valid, got.read_valid);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    cmd_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    frame_scoreboard sb;
    logic            hold_request;

    framebuffer_2d_draw_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) return 0;
        if (sel < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] act, int xs, int ys, int xe, int ye,
                                      int w, int h, int r, logic [23:0] col);
        cmd_t c;
        c.action = act;
        c.x_start = 12'(xs);
        c.y_start = 12'(ys);
        c.x_end = 12'(xe);
        c.y_end = 12'(ye);
        c.rect_width = 11'(w);
        c.rect_height = 11'(h);
        c.radius = 11'(r);
        c.color_rgb = col;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int sel;
        c = cmd_t'(CMD_W'({$urandom, $urandom, $urandom, $urandom}));
        sel = $urandom_range(99);
        if (sel < 35) c.action = ACT_READ;
        else if (sel < 52) c.action = ACT_PIXEL;
        else if (sel < 70) c.action = ACT_LINE;
        else if (sel < 84) c.action = ACT_RECT;
        else if (sel < 97) c.action = ACT_CIRCLE;
        else c.action = 3'($urandom_range(6, 7));
        if ($urandom_range(99) >= 3)
        begin
            c.x_start = 12'(int'($urandom_range(0, 840)) - 20);
            c.y_start = 12'(int'($urandom_range(0, 640)) - 20);
            c.x_end = 12'(int'(c.x_start) + int'($urandom_range(0, 80)) - 40);
            c.y_end = 12'(int'(c.y_start) + int'($urandom_range(0, 80)) - 40);
            c.rect_width = 11'($urandom_range(0, 40));
            c.rect_height = 11'($urandom_range(0, 40));
            c.radius = 11'($urandom_range(0, 40));
        end
        return c;
    endfunction

    task automatic send_cmd(cmd_t c, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && in_valid && in_ready) sb.note(in_data);
        if (rst_n && out_valid && out_ready) sb.check(out_data);
    end

    initial
    begin
        int stalled;
        bit held;
        out_ready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                out_ready <= 1'b0;
                stalled = 0;
                while (stalled < 600)
                begin
                    @(posedge clk);
                    stalled++;
                end
                held = 1'b1;
            end
            else if ($urandom_range(99) < 25)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(99) < 10) repeat ($urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        cmd_t dir[$];
        sb = new();
        hold_request = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 24'($urandom)));
        dir.push_back(make_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF));
        dir.push_back(make_cmd(ACT_PIXEL, 799, 599, 0, 0, 0, 0, 0, 24'h000000));
        dir.push_back(make_cmd(ACT_PIXEL, -2048, 2047, 0, 0, 0, 0, 0, 24'h123456));
        dir.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_cmd(ACT_READ, 799, 599, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_cmd(ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_cmd(ACT_READ, 800, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_cmd(ACT_READ, 0, 600, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_cmd(ACT_LINE, 10, 10, 60, 10, 0, 0, 0, 24'hAA0055));
        dir.push_back(make_cmd(ACT_LINE, 20, 70, 20, 5, 0, 0, 0, 24'h00FF00));
        dir.push_back(make_cmd(ACT_LINE, 790, 590, 830, 630, 0, 0, 0, 24'h0000FF));
        dir.push_back(make_cmd(ACT_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 24'h555555));
        dir.push_back(make_cmd(ACT_LINE, 5, 5, 5, 5, 0, 0, 0, 24'h777777));
        dir.push_back(make_cmd(ACT_RECT, 100, 100, 0, 0, 0, 30, 0, 24'h111111));
        dir.push_back(make_cmd(ACT_RECT, 100, 100, 0, 0, 30, 0, 0, 24'h222222));
        dir.push_back(make_cmd(ACT_RECT, 300, 300, 0, 0, 1, 1, 0, 24'h333333));
        dir.push_back(make_cmd(ACT_RECT, 780, -10, 0, 0, 40, 30, 0, 24'h444444));
        dir.push_back(make_cmd(ACT_RECT, -2048, -2048, 0, 0, 2047, 2047, 0, 24'h999999));
        dir.push_back(make_cmd(ACT_CIRCLE, 400, 300, 0, 0, 0, 0, 0, 24'hCCCCCC));
        dir.push_back(make_cmd(ACT_CIRCLE, 3, 597, 0, 0, 0, 0, 9, 24'hDDDDDD));
        dir.push_back(make_cmd(ACT_CIRCLE, 400, 300, 0, 0, 0, 0, 2047, 24'hEEEEEE));
        dir.push_back(make_cmd(3'd6, 1, 1, 0, 0, 0, 0, 0, 24'hABCDEF));
        dir.push_back(make_cmd(3'd7, 1, 1, 0, 0, 0, 0, 0, 24'hABCDEF));
        dir.push_back(make_cmd(ACT_READ, 400, 300, 0, 0, 0, 0, 0, 0));
        foreach (dir[i]) send_cmd(dir[i], pick_gap());

        for (int n = 0; n < 1000; n++)
        begin
            if (n == 400) hold_request = 1'b1;
            send_cmd(random_cmd(), (n >= 400 && n < 420) ? 0 : pick_gap());
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
sv/fbde_pkg.sv
sv/fbde_ram.sv
sv/fbde_plot.sv
sv/framebuffer_2d_draw_engine.sv
bench/framebuffer_2d_draw_engine_tb.sv
